// File: src/eida_pkg.sv
// ----------------------------------------------------------------------------
// eida_pkg
// Shared types and codes for the entity id allocator: request and result
// beats, the classified command, and the back-end state encoding.
// ----------------------------------------------------------------------------
package eida_pkg;

  // request type codes as they arrive on the input beat
  localparam logic [2:0] REQ_CREATE   = 3'd0;
  localparam logic [2:0] REQ_DESTROY  = 3'd1;
  localparam logic [2:0] REQ_SET_SIG  = 3'd2;
  localparam logic [2:0] REQ_READ     = 3'd3;
  localparam logic [2:0] REQ_SET_INIT = 3'd4;
  localparam logic [2:0] REQ_SET_UPD  = 3'd5;
  localparam logic [2:0] REQ_LIST     = 3'd6;

  // status codes on the result beat
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;
  localparam logic [1:0] STATUS_NO_LIVE  = 2'd3;

  // a list request emits at most this many beats
  localparam int MAX_RESULTS = 32;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  entity_id;
    logic [31:0] signature_in;
    logic        flag_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  result_id;
    logic [31:0] signature_out;
    logic        initialized_out;
    logic        updated_out;
    logic        live_out;
    logic [5:0]  live_total;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DESTROY,
    OP_SET_SIG,
    OP_READ,
    OP_SET_INIT,
    OP_SET_UPD,
    OP_LIST
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [4:0]  id;
    logic        in_range;
    logic [31:0] sig;
    logic        flag;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

// File: src/eida_fifo.sv
// ----------------------------------------------------------------------------
// eida_fifo
// Small register queue with full and empty flags; the head entry is shown
// combinationally on dout.
// ----------------------------------------------------------------------------
module eida_fifo #(
  parameter int W  = 8,
  parameter int AW = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

endmodule

// File: src/eida_front.sv
// ----------------------------------------------------------------------------
// eida_front
// Takes request beats, decodes the request type, range-checks the target id,
// masks the signature and queues the command for the back end.
// ----------------------------------------------------------------------------
module eida_front #(
  parameter int NUM_ENTITIES = 32,
  parameter int SIG_BITS     = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eida_pkg::item_t item,
  output logic            full,
  output logic            cmd_valid,
  output eida_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);
  import eida_pkg::*;

  localparam int SW = (SIG_BITS < 32) ? SIG_BITS : 32;
  localparam logic [31:0] SIG_MASK = 32'((64'(1) << SW) - 64'(1));

  cmd_t                cls;
  logic                keep;
  logic [$bits(cmd_t)-1:0] q_dout;
  logic                q_empty;

  // decode request type; the unused code is dropped here
  always_comb begin
    keep = 1'b1;
    cls.op = OP_READ;
    case (item.req_type)
      REQ_CREATE:   cls.op = OP_CREATE;
      REQ_DESTROY:  cls.op = OP_DESTROY;
      REQ_SET_SIG:  cls.op = OP_SET_SIG;
      REQ_READ:     cls.op = OP_READ;
      REQ_SET_INIT: cls.op = OP_SET_INIT;
      REQ_SET_UPD:  cls.op = OP_SET_UPD;
      REQ_LIST:     cls.op = OP_LIST;
      default:      keep = 1'b0;
    endcase
    cls.id       = item.entity_id;
    cls.in_range = (32'(item.entity_id) < 32'(NUM_ENTITIES));
    cls.sig      = item.signature_in & SIG_MASK;
    cls.flag     = item.flag_in;
  end

  // command queue between front and back
  eida_fifo #(
    .W  ($bits(cmd_t)),
    .AW (1)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .din   (cls),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign cmd       = cmd_t'(q_dout);
  assign cmd_valid = !q_empty;

endmodule

// File: src/eida_back.sv
// ----------------------------------------------------------------------------
// eida_back
// Executes classified commands: owns the free-id queue, the per-id live and
// flag bits and the signature memory, and walks the live bits for a list.
// ----------------------------------------------------------------------------
module eida_back #(
  parameter int NUM_ENTITIES = 32,
  parameter int SIG_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  eida_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output eida_pkg::result_t res
);
  import eida_pkg::*;

  localparam int IDW = $clog2(NUM_ENTITIES);
  localparam int CW  = $clog2(NUM_ENTITIES + 1);
  localparam int SW  = (SIG_BITS < 32) ? SIG_BITS : 32;

  back_state_t state, state_next;

  cmd_t              cur;
  logic [IDW-1:0]    cur_id;
  logic [IDW-1:0]    head;
  logic [IDW-1:0]    tail;
  logic [CW-1:0]     live_count;
  logic [EMIT_W-1:0] emitted;

  logic [NUM_ENTITIES-1:0] live_bits;
  logic [NUM_ENTITIES-1:0] init_bits;
  logic [NUM_ENTITIES-1:0] upd_bits;
  logic [NUM_ENTITIES-1:0] sig_valid;
  logic [NUM_ENTITIES-1:0] fq_written;

  logic [SW-1:0]  sig_mem [NUM_ENTITIES];
  logic [SW-1:0]  sig_rd;
  logic [IDW-1:0] fq_mem [NUM_ENTITIES];
  logic [IDW-1:0] fq_rd;
  logic [IDW-1:0] fq_rd_addr;
  logic           fq_rd_init;

  logic [IDW-1:0] sig_raddr;
  logic [IDW-1:0] nid;
  logic [SW-1:0]  cur_sig;
  logic           cur_init;
  logic           cur_upd;
  logic           cur_live;
  logic           q_empty;
  logic           alloc_ok;
  logic           free_ok;
  logic           exec_go;
  logic           emit_go;
  logic           list_last;
  result_t        exec_res;
  result_t        list_res;

  function automatic logic [IDW-1:0] wrap_inc(input logic [IDW-1:0] p);
    if (p == IDW'(NUM_ENTITIES - 1)) return '0;
    return p + 1'b1;
  endfunction

  // current entry as seen after the read stage
  assign nid      = fq_rd_init ? fq_rd_addr : fq_rd;
  assign cur_sig  = sig_valid[cur_id] ? sig_rd : '0;
  assign cur_init = init_bits[cur_id];
  assign cur_upd  = upd_bits[cur_id];
  assign cur_live = live_bits[cur_id];
  assign q_empty  = (live_count == CW'(NUM_ENTITIES));
  assign alloc_ok = (cur.op == OP_CREATE) && !q_empty;
  assign free_ok  = (cur.op == OP_DESTROY) && cur.in_range && cur_live;
  assign exec_go  = (state == ST_EXEC) && !res_full;
  assign emit_go  = (state == ST_EMIT) && !res_full;
  assign list_last = (32'(emitted) + 1 == 32'(live_count)) ||
                     (32'(emitted) == MAX_RESULTS - 1);

  // result of a single-beat command
  always_comb begin
    exec_res = '0;
    exec_res.last = 1'b1;
    exec_res.live_total = 6'(live_count);
    case (cur.op)
      OP_CREATE: begin
        if (q_empty) begin
          exec_res.status = STATUS_NO_FREE;
        end else begin
          exec_res.status          = STATUS_OK;
          exec_res.result_id       = 5'(cur_id);
          exec_res.signature_out   = 32'(cur_sig);
          exec_res.updated_out     = 1'b1;
          exec_res.live_out        = 1'b1;
          exec_res.live_total      = 6'(live_count + CW'(1));
        end
      end
      OP_DESTROY: begin
        exec_res.result_id = cur.id;
        if (free_ok) begin
          exec_res.status     = STATUS_OK;
          exec_res.live_total = 6'(live_count - CW'(1));
        end else begin
          exec_res.status = STATUS_NOT_LIVE;
          if (cur.in_range) begin
            exec_res.signature_out   = 32'(cur_sig);
            exec_res.initialized_out = cur_init;
            exec_res.updated_out     = cur_upd;
            exec_res.live_out        = cur_live;
          end
        end
      end
      OP_LIST: begin
        exec_res.status = STATUS_NO_LIVE;
      end
      default: begin
        exec_res.result_id = cur.id;
        if (!cur.in_range) begin
          exec_res.status = STATUS_NOT_LIVE;
        end else begin
          exec_res.status          = STATUS_OK;
          exec_res.signature_out   = (cur.op == OP_SET_SIG) ? 32'(SW'(cur.sig))
                                                            : 32'(cur_sig);
          exec_res.initialized_out = (cur.op == OP_SET_INIT) ? cur.flag : cur_init;
          exec_res.updated_out     = (cur.op == OP_SET_UPD) ? cur.flag : cur_upd;
          exec_res.live_out        = cur_live;
        end
      end
    endcase
  end

  // result of one list beat
  always_comb begin
    list_res = '0;
    list_res.status          = STATUS_OK;
    list_res.result_id       = 5'(cur_id);
    list_res.signature_out   = 32'(cur_sig);
    list_res.initialized_out = cur_init;
    list_res.updated_out     = cur_upd;
    list_res.live_out        = 1'b1;
    list_res.live_total      = 6'(live_count);
    list_res.last            = list_last;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state, handshakes and signature read address
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = exec_res;
    sig_raddr  = cur_id;
    case (state)
      ST_IDLE: begin
        sig_raddr = IDW'(cmd.id);
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_CREATE && live_count != CW'(NUM_ENTITIES)) begin
            state_next = ST_ALLOC;
          end else if (cmd.op == OP_LIST && live_count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_ALLOC: begin
        sig_raddr  = nid;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (live_bits[cur_id]) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        res = list_res;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = list_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command and scan position
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cur    <= cmd;
      cur_id <= (cmd.op == OP_LIST) ? '0 : IDW'(cmd.id);
    end else if (state == ST_ALLOC) begin
      cur_id <= nid;
    end else if (state == ST_SCAN && !live_bits[cur_id]) begin
      cur_id <= cur_id + 1'b1;
    end else if (emit_go && !list_last) begin
      cur_id <= cur_id + 1'b1;
    end
  end

  // allocator state and per-id bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      live_count <= '0;
      emitted    <= '0;
      live_bits  <= '0;
      init_bits  <= '0;
      upd_bits   <= '0;
      sig_valid  <= '0;
      fq_written <= '0;
    end else begin
      if (state == ST_IDLE) emitted <= '0;
      else if (emit_go) emitted <= emitted + 1'b1;
      if (exec_go) begin
        if (alloc_ok) begin
          live_bits[cur_id] <= 1'b1;
          init_bits[cur_id] <= 1'b0;
          upd_bits[cur_id]  <= 1'b1;
          head              <= wrap_inc(head);
          live_count        <= live_count + 1'b1;
        end
        if (free_ok) begin
          live_bits[cur_id]  <= 1'b0;
          init_bits[cur_id]  <= 1'b0;
          upd_bits[cur_id]   <= 1'b0;
          sig_valid[cur_id]  <= 1'b0;
          fq_written[tail]   <= 1'b1;
          tail               <= wrap_inc(tail);
          live_count         <= live_count - 1'b1;
        end
        if (cur.in_range) begin
          if (cur.op == OP_SET_SIG) sig_valid[cur_id] <= 1'b1;
          if (cur.op == OP_SET_INIT) init_bits[cur_id] <= cur.flag;
          if (cur.op == OP_SET_UPD) upd_bits[cur_id] <= cur.flag;
        end
      end
    end
  end

  // signature memory and free-id queue memory
  always_ff @(posedge clk) begin
    if (exec_go && cur.in_range && cur.op == OP_SET_SIG) begin
      sig_mem[cur_id] <= SW'(cur.sig);
    end
    if (exec_go && free_ok) begin
      fq_mem[tail] <= cur_id;
    end
    sig_rd     <= sig_mem[sig_raddr];
    fq_rd      <= fq_mem[head];
    fq_rd_addr <= head;
    fq_rd_init <= !fq_written[head];
  end

endmodule

// File: src/entity_id_allocator_table.sv
// Flow: a request's beat waits in the command queue until the back end takes it in
// its idle state; a create that allocates then passes the alloc state, and the exec
// state pushes the result into the result queue. A list walks ids in the scan state and
// pushes one beat per live id from the emit state. The back end takes a new request only
// when back in idle, and a full result queue stalls it; the extra states serve its registered
// signature and free-queue memory reads. Reset: control state clears; no memory clearing pass.
// ----------------------------------------------------------------------------
// entity_id_allocator_table
// Entity id allocator with a fifo free list, per-id live and flag bits and a
// signature store, split into a classifying front end and an executing back
// end joined by a short command queue.
// ----------------------------------------------------------------------------
module entity_id_allocator_table #(
  parameter int NUM_ENTITIES = 32,
  parameter int SIG_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  eida_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output eida_pkg::result_t result,
  output logic              empty
);
  import eida_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t res;
  logic [$bits(result_t)-1:0] rq_dout;

  // front end: accept and classify
  eida_front #(
    .NUM_ENTITIES (NUM_ENTITIES),
    .SIG_BITS     (SIG_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back end: execute against the tables
  eida_back #(
    .NUM_ENTITIES (NUM_ENTITIES),
    .SIG_BITS     (SIG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue toward the consumer
  eida_fifo #(
    .W  ($bits(result_t)),
    .AW (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (rq_dout),
    .empty (empty)
  );

  assign result = result_t'(rq_dout);

  // back end never pushes into a full result queue
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  // a rejected create only happens with every id live
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_NO_FREE) |-> (result.live_total == 6'(NUM_ENTITIES)))
    else $error("no free id reported while ids remain");

  // only list beats of live ids may come without last
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.last) |-> (result.status == STATUS_OK && result.live_out))
    else $error("non-final beat that is not a live list entry");

  // result queue is empty right after reset
  assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule
